### src/fqsf_pkg.sv
// Package for the FIFO queue with sum filter: sizes, codes, FSM states and control structs.
package fqsf_pkg;

  // Queue capacity and derived widths
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned DIVC_W  = $clog2(DATA_W);

  // Operation codes carried in func
  typedef enum logic [FUNC_W-1:0] {
    OP_ENQ  = 3'd0,
    OP_DEQ  = 3'd1,
    OP_SUM  = 3'd2,
    OP_AVG  = 3'd3,
    OP_RNEG = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Source of the result value
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_SUM,
    RES_RDATA,
    RES_DIV
  } res_src_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_DQ_WAIT,
    S_DIV,
    S_DIV_END,
    S_RN_RD,
    S_RN_WR,
    S_RN_END,
    S_HOLD
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     req_ready;
    logic     enq_do;
    logic     deq_rd;
    logic     deq_do;
    logic     div_init;
    logic     div_step;
    logic     rn_init;
    logic     rn_rd;
    logic     rn_wr;
    logic     rn_end;
    logic     fin;
    res_src_e res_src;
    status_e  res_status;
    logic     out_load_new;
    logic     out_load_old;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic              req_valid;
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              div_last;
    logic              rn_last;
    logic              slot_free;
  } stat_t;

  // Ring index increment for any depth
  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(DEPTH - 1)) begin
      return '0;
    end
    return idx + IDX_W'(1);
  endfunction

  // Held count truncated or extended to the output field
  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+COUNT_W-1:0] ext;
    ext = {{COUNT_W{1'b0}}, cnt};
    return ext[COUNT_W-1:0];
  endfunction

endpackage

### src/fqsf_if.sv
// Valid/ready channel interfaces for request and response transactions.
interface fqsf_in_if import fqsf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] value_in;

  modport source (output valid, func, value_in, input ready);
  modport sink   (input valid, func, value_in, output ready);
endinterface

interface fqsf_out_if import fqsf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value_out;
  logic [STAT_W-1:0]        status;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, value_out, status, count, input ready);
  modport sink   (input valid, value_out, status, count, output ready);
endinterface

### src/fifo_queue_with_sum_filter.sv
// Top level of the FIFO queue with running sum, average and negative-value filter.
//
// Requests arrive on req_i (func, value_in) and each produces exactly one
// response on rsp_o (value_out, status, count). A transaction moves when
// valid and ready are both high at a rising clock edge.
// One request is worked on at a time; ready is high only while the
// controller is idle. The steps of each operation after acceptance:
//   enqueue, sum, unused codes, empty dequeue and average: execute step
//   dequeue: one registered memory read, then the result is taken
//   average: one quotient bit per cycle over 32 bits of sum
//   remove negatives: read then write per held entry, in separate
//   steps, then a step that sets the new tail, count and sum
// The response sits in an output register. If the receiver stalls, the
// finished result is parked and the controller waits until it can hand it
// over; no new request is taken in the meantime.
// Reset (rst_ni low) empties the queue: pointers, count, running sum and
// the output valid clear at once. Entry storage is not cleared.
module fifo_queue_with_sum_filter import fqsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fqsf_in_if.sink    req_i,
  fqsf_out_if.source rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  fqsf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  fqsf_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // Never enqueue into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.enq_do |-> !stat.full)
    else $error("enqueue issued while full");

  // Dequeue consumes read data fetched the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.deq_do |-> $past(cmd.deq_rd))
    else $error("dequeue without a preceding read");

  // Filter write step follows its read step
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.rn_wr |-> $past(cmd.rn_rd))
    else $error("filter write without a preceding read");

  // Output register is only loaded when the slot is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load_new || cmd.out_load_old) |-> stat.slot_free)
    else $error("output overwritten while stalled");

  // Request accepted only while no response is pending in the controller
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> !cmd.fin)
    else $error("request accepted during a finishing step");

endmodule

### src/fqsf_ctrl.sv
// Controller state machine: sequences each operation and the output handoff.
module fqsf_ctrl import fqsf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  op_e    op;

  assign op = op_e'(stat_i.func);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (stat_i.req_valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (op)
          OP_DEQ:  state_d = stat_i.empty ? (stat_i.slot_free ? S_IDLE : S_HOLD) : S_DQ_WAIT;
          OP_AVG:  state_d = stat_i.empty ? (stat_i.slot_free ? S_IDLE : S_HOLD) : S_DIV;
          OP_RNEG: state_d = stat_i.empty ? S_RN_END : S_RN_RD;
          default: state_d = stat_i.slot_free ? S_IDLE : S_HOLD;
        endcase
      end
      S_DQ_WAIT, S_DIV_END, S_RN_END: begin
        state_d = stat_i.slot_free ? S_IDLE : S_HOLD;
      end
      S_DIV: begin
        if (stat_i.div_last) state_d = S_DIV_END;
      end
      S_RN_RD: state_d = S_RN_WR;
      S_RN_WR: state_d = stat_i.rn_last ? S_RN_END : S_RN_RD;
      S_HOLD: begin
        if (stat_i.slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_src    = RES_ZERO;
    cmd_o.res_status = ST_OK;
    unique case (state_q)
      S_IDLE: cmd_o.req_ready = 1'b1;
      S_EXEC: begin
        unique case (op)
          OP_ENQ: begin
            cmd_o.enq_do     = !stat_i.full;
            cmd_o.fin        = 1'b1;
            cmd_o.res_status = stat_i.full ? ST_FULL : ST_OK;
          end
          OP_DEQ: begin
            cmd_o.deq_rd     = !stat_i.empty;
            cmd_o.fin        = stat_i.empty;
            cmd_o.res_status = stat_i.empty ? ST_EMPTY : ST_OK;
          end
          OP_SUM: begin
            cmd_o.fin     = 1'b1;
            cmd_o.res_src = RES_SUM;
          end
          OP_AVG: begin
            cmd_o.div_init   = !stat_i.empty;
            cmd_o.fin        = stat_i.empty;
            cmd_o.res_status = stat_i.empty ? ST_EMPTY : ST_OK;
          end
          OP_RNEG: cmd_o.rn_init = 1'b1;
          default: cmd_o.fin = 1'b1;
        endcase
      end
      S_DQ_WAIT: begin
        cmd_o.deq_do  = 1'b1;
        cmd_o.fin     = 1'b1;
        cmd_o.res_src = RES_RDATA;
      end
      S_DIV:     cmd_o.div_step = 1'b1;
      S_DIV_END: begin
        cmd_o.fin     = 1'b1;
        cmd_o.res_src = RES_DIV;
      end
      S_RN_RD:  cmd_o.rn_rd = 1'b1;
      S_RN_WR:  cmd_o.rn_wr = 1'b1;
      S_RN_END: begin
        cmd_o.rn_end = 1'b1;
        cmd_o.fin    = 1'b1;
      end
      S_HOLD:  cmd_o.out_load_old = stat_i.slot_free;
      default: cmd_o.req_ready = 1'b0;
    endcase
    cmd_o.out_load_new = cmd_o.fin && stat_i.slot_free;
  end

endmodule

### src/fqsf_dp.sv
// Datapath: entry memory, ring pointers, running sum, divider, filter walk, output register.
module fqsf_dp import fqsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  fqsf_in_if.sink          req_i,
  fqsf_out_if.source       rsp_o,
  input  cmd_t             cmd_i,
  output stat_t            stat_o
);

  // Entry storage
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Queue state
  logic [IDX_W-1:0]  head_q, tail_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] sum_q;

  // Latched request
  logic [FUNC_W-1:0] func_q;
  logic [DATA_W-1:0] value_q;

  // Divider state
  logic [DATA_W-1:0] dvd_q;
  logic [CNT_W-1:0]  rem_q;
  logic [DIVC_W-1:0] div_cnt_q;
  logic              neg_q;
  logic [CNT_W:0]    rem_sh, rem_sub;
  logic              rem_ge;
  logic [DATA_W-1:0] sum_mag;

  // Filter walk state
  logic [IDX_W-1:0]  rd_q, wr_q;
  logic [CNT_W-1:0]  rn_i_q, kept_q;
  logic [DATA_W-1:0] rs_q;
  logic              keep;

  // Result and output registers
  logic [DATA_W-1:0]  res_d, res_q;
  status_e            stat_q;
  logic [COUNT_W-1:0] cnt_res_q;
  logic               out_valid_q;
  logic [DATA_W-1:0]  out_value_q;
  logic [STAT_W-1:0]  out_status_q;
  logic [COUNT_W-1:0] out_count_q;

  logic accept;
  assign accept = req_i.valid && cmd_i.req_ready;
  assign keep   = !rdata_q[DATA_W-1];

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= req_i.func;
      value_q <= req_i.value_in;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_do) begin
      mem[tail_q] <= value_q;
    end else if (cmd_i.rn_wr && keep) begin
      mem[wr_q] <= rdata_q;
    end
    if (cmd_i.deq_rd) begin
      rdata_q <= mem[head_q];
    end else if (cmd_i.rn_rd) begin
      rdata_q <= mem[rd_q];
    end
  end

  // Held count after this cycle's operation
  always_comb begin
    count_d = count_q;
    if (cmd_i.enq_do)      count_d = count_q + CNT_W'(1);
    else if (cmd_i.deq_do) count_d = count_q - CNT_W'(1);
    else if (cmd_i.rn_end) count_d = kept_q;
  end

  // Ring pointers, count and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.enq_do) begin
        tail_q <= wrap_next(tail_q);
        sum_q  <= sum_q + value_q;
      end
      if (cmd_i.deq_do) begin
        head_q <= wrap_next(head_q);
        sum_q  <= sum_q - rdata_q;
      end
      if (cmd_i.rn_end) begin
        tail_q <= wr_q;
        sum_q  <= rs_q;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle on the magnitude
  assign sum_mag = sum_q[DATA_W-1] ? (~sum_q + DATA_W'(1)) : sum_q;
  assign rem_sh  = {rem_q, dvd_q[DATA_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, count_q};
  assign rem_sub = rem_sh - {1'b0, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q     <= sum_mag;
      rem_q     <= '0;
      div_cnt_q <= '0;
      neg_q     <= sum_q[DATA_W-1];
    end else if (cmd_i.div_step) begin
      rem_q     <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dvd_q     <= {dvd_q[DATA_W-2:0], rem_ge};
      div_cnt_q <= div_cnt_q + DIVC_W'(1);
    end
  end

  // Negative-value filter walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.rn_init) begin
      rd_q   <= head_q;
      wr_q   <= head_q;
      rn_i_q <= '0;
      kept_q <= '0;
      rs_q   <= '0;
    end else if (cmd_i.rn_wr) begin
      rd_q   <= wrap_next(rd_q);
      rn_i_q <= rn_i_q + CNT_W'(1);
      if (keep) begin
        wr_q   <= wrap_next(wr_q);
        kept_q <= kept_q + CNT_W'(1);
        rs_q   <= rs_q + rdata_q;
      end
    end
  end

  // Result select
  always_comb begin
    unique case (cmd_i.res_src)
      RES_ZERO:  res_d = '0;
      RES_SUM:   res_d = sum_q;
      RES_RDATA: res_d = rdata_q;
      RES_DIV:   res_d = neg_q ? (~dvd_q + DATA_W'(1)) : dvd_q;
      default:   res_d = '0;
    endcase
  end

  // Saved result for a stalled handoff
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      res_q     <= res_d;
      stat_q    <= cmd_i.res_status;
      cnt_res_q <= to_count(count_d);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load_new || cmd_i.out_load_old) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_new) begin
      out_value_q  <= res_d;
      out_status_q <= cmd_i.res_status;
      out_count_q  <= to_count(count_d);
    end else if (cmd_i.out_load_old) begin
      out_value_q  <= res_q;
      out_status_q <= stat_q;
      out_count_q  <= cnt_res_q;
    end
  end

  assign req_i.ready     = cmd_i.req_ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.value_out = out_value_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.count     = out_count_q;

  // Status to the controller
  assign stat_o.req_valid = req_i.valid;
  assign stat_o.func      = func_q;
  assign stat_o.full      = count_q == CNT_W'(DEPTH);
  assign stat_o.empty     = count_q == '0;
  assign stat_o.div_last  = div_cnt_q == DIVC_W'(DATA_W - 1);
  assign stat_o.rn_last   = rn_i_q == (count_q - CNT_W'(1));
  assign stat_o.slot_free = !out_valid_q || rsp_o.ready;

endmodule
